// File: rtl/core/plsu_pkg.sv
// plsu_pkg: shared types and constants of the positional list store unit.
// Holds field widths, request and status codes, and the cell and scanner
// control structs. Depends on nothing.
package plsu_pkg;

  localparam int CAPACITY_DEF = 128;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 8;
  localparam int REQ_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int FIDX_W       = 7;
  localparam int ECNT_W       = 8;
  localparam int SCAN_GRP     = 8;   // hit flags examined per scan cycle
  localparam int SCAN_ENC_W   = 3;   // bits of an index within one scan group

  localparam logic [REQ_W-1:0] REQ_FIND   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [VALUE_W-1:0]  value;
  } cell_cmd_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

endpackage

// File: rtl/core/positional_list_store_unit.sv
// positional_list_store_unit: top level of the positional list store.
// Depends on plsu_pkg, plsu_cell and plsu_scan.
//
// Usage:
//   Input channel in_*: one request per transfer, in_tdata packs req_type,
//   value and position. Output channel out_*: one result per request,
//   out_tdata packs status, found_index and entry_count.
//   The list lives in a row of CAPACITY cells. Insert and delete are
//   resolved in the accepting cycle: on insert each cell past the slot takes
//   its lower neighbor and the slot cell the new value, on delete each cell
//   at or past the slot takes its upper neighbor; the result is valid in the
//   next cycle. A find compares every cell in the accepting cycle, then
//   scans the hit flags eight per cycle, and its result is registered once
//   the scan ends. in_tready stays low during a scan. Insert, delete and
//   refused requests sustain one transfer per cycle while out_tready is high.
//   A result held in the output register does not block the next request:
//   in_tready stays high while the output drains in the same cycle.
//   When the receiver stalls with a result pending, in_tready drops until
//   the result is taken. Reset empties the list (count zero) and clears
//   both channels; cell contents are not cleared and are never read
//   beyond the count.
module positional_list_store_unit
  import plsu_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [1:0] req_type, [33:2] value, [41:34] position
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [1:0] status, [8:2] found_index, [16:9] entry_count
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int XW = IW + FIDX_W;
  localparam int EW = CW + ECNT_W;

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t               state_r;
  logic                 out_tvalid_r;
  status_t              out_status_r;
  logic [FIDX_W-1:0]    out_idx_r;
  logic [ECNT_W-1:0]    out_cnt_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;

  logic [REQ_W-1:0]     in_req;
  logic [VALUE_W-1:0]   in_value;
  logic [POS_W-1:0]     in_pos;
  logic                 in_acc;
  logic                 out_free;

  logic [PW-1:0]        pos_w;
  logic [PW-1:0]        cnt_w;
  logic [PW-1:0]        slot_w;
  logic [IW-1:0]        slot;
  status_t              res_status;
  cell_cmd_t            cmd;

  logic [VALUE_W-1:0]   cell_q [CAPACITY];
  logic [CAPACITY-1:0]  hits;
  scan_stat_t           scan_stat;
  logic [IW-1:0]        scan_idx;
  logic [XW-1:0]        scan_idx_x;
  logic [EW-1:0]        cnt_x;
  logic [EW-1:0]        cnt_nxt_x;

  // unpack the request
  assign in_req   = in_tdata[1:0];
  assign in_value = in_tdata[33:2];
  assign in_pos   = in_tdata[41:34];

  // output register frees up when empty or draining this cycle
  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  // range checks on the request against the current count
  assign pos_w  = PW'(in_pos);
  assign cnt_w  = PW'(count_r);
  assign slot_w = pos_w - PW'(1);
  assign slot   = slot_w[IW-1:0];

  always_comb begin
    res_status = ST_OK;
    count_nxt  = count_r;
    cmd.op     = CELL_HOLD;
    cmd.value  = in_value;
    unique case (in_req)
      REQ_INSERT: begin
        // full is checked before the position
        if (cnt_w >= PW'(CAPACITY)) begin
          res_status = ST_FULL;
        end else if ((in_pos == '0) || (pos_w > cnt_w + PW'(1))) begin
          res_status = ST_BADPOS;
        end else begin
          count_nxt = count_r + CW'(1);
          if (in_acc) begin
            cmd.op = CELL_INS;
          end
        end
      end
      REQ_DELETE: begin
        if ((in_pos == '0) || (pos_w > cnt_w)) begin
          res_status = ST_BADPOS;
        end else begin
          count_nxt = count_r - CW'(1);
          if (in_acc) begin
            cmd.op = CELL_DEL;
          end
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // row of entry cells; each end gets a harmless neighbor
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [VALUE_W-1:0] left_d;
    logic [VALUE_W-1:0] right_d;
    if (k == 0) begin : g_first
      assign left_d = in_value;
    end else begin : g_mid_l
      assign left_d = cell_q[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_d = cell_q[k];
    end else begin : g_mid_r
      assign right_d = cell_q[k+1];
    end
    plsu_cell #(
      .INDEX (k),
      .IW    (IW),
      .CW    (CW)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .slot    (slot),
      .count   (count_r),
      .left_i  (left_d),
      .right_i (right_d),
      .data_o  (cell_q[k]),
      .hit_o   (hits[k])
    );
  end

  plsu_scan #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc && (in_req == REQ_FIND)),
    .hits  (hits),
    .stat  (scan_stat),
    .idx   (scan_idx)
  );

  assign scan_idx_x = XW'(scan_idx);
  assign cnt_x      = EW'(count_r);
  assign cnt_nxt_x  = EW'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      count_r      <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (in_req != REQ_FIND)) begin
            // insert, delete, refused and unused codes answer at once
            count_r      <= count_nxt;
            out_tvalid_r <= 1'b1;
            out_status_r <= res_status;
            out_idx_r    <= '0;
            out_cnt_r    <= cnt_nxt_x[ECNT_W-1:0];
          end else begin
            if (in_acc) begin
              state_r <= S_SCAN;
            end
            // drop the result once the receiver takes it
            if (out_tready) begin
              out_tvalid_r <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          // output register is empty throughout the scan
          if (scan_stat.done) begin
            state_r      <= S_IDLE;
            out_tvalid_r <= 1'b1;
            out_status_r <= scan_stat.found ? ST_OK : ST_NOTFOUND;
            out_idx_r    <= scan_stat.found ? scan_idx_x[FIDX_W-1:0] : '0;
            out_cnt_r    <= cnt_x[ECNT_W-1:0];
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, out_cnt_r, out_idx_r, out_status_r};

endmodule

// File: rtl/core/plsu_cell.sv
// plsu_cell: one entry of the list row with its neighbor moves and compare.
// Depends on plsu_pkg.
module plsu_cell
  import plsu_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int IW    = 7,
  parameter int CW    = 8
) (
  input  logic                clk,
  input  cell_cmd_t           cmd,
  input  logic [IW-1:0]       slot,
  input  logic [CW-1:0]       count,
  input  logic [VALUE_W-1:0]  left_i,
  input  logic [VALUE_W-1:0]  right_i,
  output logic [VALUE_W-1:0]  data_o,
  output logic                hit_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
  localparam logic [CW-1:0] MY_CNT = CW'(INDEX);

  logic [VALUE_W-1:0] data_r;
  logic [VALUE_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      CELL_INS: begin
        // take the neighbor below past the slot, the new value at it
        if (MY_IDX > slot) begin
          data_nxt = left_i;
        end else if (MY_IDX == slot) begin
          data_nxt = cmd.value;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= slot) begin
          data_nxt = right_i;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign hit_o  = (data_r == cmd.value) && (MY_CNT < count);

endmodule

// File: rtl/core/plsu_scan.sv
// plsu_scan: finds the lowest set hit flag, one group of flags per cycle.
// Depends on plsu_pkg.
module plsu_scan
  import plsu_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IW       = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [CAPACITY-1:0] hits,
  output scan_stat_t          stat,
  output logic [IW-1:0]       idx
);

  localparam int NG   = (CAPACITY + SCAN_GRP - 1) / SCAN_GRP;
  localparam int PADW = NG * SCAN_GRP;
  localparam int LW   = $clog2(NG + 1);
  localparam int SW   = IW + SCAN_ENC_W;

  logic [PADW-1:0]       sh_r;
  logic [IW-1:0]         base_r;
  logic [LW-1:0]         left_r;
  logic                  busy_r;
  logic [SCAN_GRP-1:0]   low;
  logic [SCAN_ENC_W-1:0] enc;
  logic [SW-1:0]         sum;

  assign low = sh_r[SCAN_GRP-1:0];

  always_comb begin
    enc = '0;
    for (int i = SCAN_GRP - 1; i >= 0; i--) begin
      if (low[i]) begin
        enc = SCAN_ENC_W'(i);
      end
    end
  end

  assign sum        = SW'(base_r) + SW'(enc);
  assign idx        = sum[IW-1:0];
  assign stat.found = busy_r && (|low);
  assign stat.done  = busy_r && ((|low) || (left_r == LW'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      sh_r   <= PADW'(hits);
      base_r <= '0;
      left_r <= LW'(NG);
    end else if (busy_r) begin
      if (stat.done) begin
        busy_r <= 1'b0;
      end else begin
        // advance to the next group
        sh_r   <= sh_r >> SCAN_GRP;
        base_r <= base_r + IW'(SCAN_GRP);
        left_r <= left_r - LW'(1);
      end
    end
  end

endmodule

// File: rtl/core/plsu_checker.sv
// plsu_checker: port-level assertions for positional_list_store_unit,
// attached by bind. Depends on plsu_pkg.
module plsu_checker
  import plsu_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  localparam logic [ECNT_W-1:0] CAP_LOW = ECNT_W'(CAPACITY);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // reset empties the output channel
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a refusal for a full list reports the full count
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ST_FULL) |-> out_tdata[16:9] == CAP_LOW)
    else $error("full status with count below capacity");

  // only a successful request may carry a nonzero index
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != ST_OK) |-> out_tdata[8:2] == '0)
    else $error("nonzero index on failed request");

  // a new request is never taken while a stalled result waits
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("request taken over stalled result");

endmodule

bind positional_list_store_unit plsu_checker #(.CAPACITY(CAPACITY)) u_plsu_checker (.*);
